FILE: rtl/r2fft_pkg.sv
// r2fft_pkg: shared constants, types and twiddle table for the radix-2 fft core
// no dependencies
package r2fft_pkg;

	localparam int MaxPointsDef  = 64;
	localparam int SampleBitsDef = 16;
	localparam int ValBits       = 23;
	localparam int TwLog         = 6;
	localparam int CfgAddrBits   = 3;

	localparam logic [CfgAddrBits-1:0] RegLog2Points  = 3'd0;
	localparam logic [CfgAddrBits-1:0] RegInverseMode = 3'd4;

	typedef logic signed [ValBits-1:0] val_t;
	typedef logic signed [16:0] tw_t;

	// cos table for one quarter, q1.15, 1.0 exact
	function automatic tw_t quarter_cos(input logic [4:0] m);
		tw_t r;
		begin
			unique case (m)
				5'd0: r = 17'sd32768;
				5'd1: r = 17'sd32610;
				5'd2: r = 17'sd32138;
				5'd3: r = 17'sd31357;
				5'd4: r = 17'sd30274;
				5'd5: r = 17'sd28899;
				5'd6: r = 17'sd27246;
				5'd7: r = 17'sd25330;
				5'd8: r = 17'sd23170;
				5'd9: r = 17'sd20788;
				5'd10: r = 17'sd18205;
				5'd11: r = 17'sd15447;
				5'd12: r = 17'sd12540;
				5'd13: r = 17'sd9512;
				5'd14: r = 17'sd6393;
				5'd15: r = 17'sd3212;
				default: r = 17'sd0;
			endcase
			return r;
		end
	endfunction

	// twiddle for angle 2*pi*m/64, m in 0..31
	function automatic void twiddle(input logic [4:0] m, output tw_t c, output tw_t s);
		begin
			if (m <= 5'd16) begin
				c = quarter_cos(m);
				s = quarter_cos(5'd16 - m);
			end else begin
				c = -quarter_cos(5'd0 - m);
				s = quarter_cos(m - 5'd16);
			end
		end
	endfunction

	function automatic val_t sat23(input logic signed [ValBits+1:0] x);
		begin
			if (x > 25'sd4194303) return 23'sh3FFFFF;
			else if (x < -25'sd4194304) return 23'sh400000;
			else return x[ValBits-1:0];
		end
	endfunction

endpackage

FILE: rtl/r2fft_ram.sv
// r2fft_ram: generic single-write, single-read ram with registered read
// no dependencies
module r2fft_ram #(
	parameter int Width = 23,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/r2fft_bfly.sv
// r2fft_bfly: shared butterfly datapath, twiddle multiply registered before add
// depends on r2fft_pkg
module r2fft_bfly import r2fft_pkg::*; (
	input  logic       clk,
	input  logic [4:0] tw_idx,
	input  logic       inverse,
	input  val_t       ur,
	input  val_t       ui,
	input  val_t       vr,
	input  val_t       vi,
	output val_t       xr,
	output val_t       xi,
	output val_t       yr,
	output val_t       yi
);
	tw_t c, s, wi;
	logic signed [40:0] p_rc_q, p_iw_q, p_rw_q, p_ic_q;
	val_t ur_q, ui_q;
	logic signed [41:0] sr, si;
	logic signed [26:0] tr, ti;

	always_comb begin
		twiddle(tw_idx, c, s);
		wi = inverse ? s : -s;
	end

	// products registered, then summed and rounded
	always_ff @(posedge clk) begin
		p_rc_q <= 41'(vr * c);
		p_iw_q <= 41'(vi * wi);
		p_rw_q <= 41'(vr * wi);
		p_ic_q <= 41'(vi * c);
		ur_q   <= ur;
		ui_q   <= ui;
	end

	always_comb begin
		sr = 42'(p_rc_q) - 42'(p_iw_q) + 42'sd16384;
		si = 42'(p_rw_q) + 42'(p_ic_q) + 42'sd16384;
		tr = 27'(sr >>> 15);
		ti = 27'(si >>> 15);
		xr = sat23(25'(27'(ur_q) + tr));
		xi = sat23(25'(27'(ui_q) + ti));
		yr = sat23(25'(27'(ur_q) - tr));
		yi = sat23(25'(27'(ui_q) - ti));
	end
endmodule

FILE: rtl/radix2_complex_fft_core.sv
// radix2_complex_fft_core: iterative radix-2 dit fft, one shared butterfly unit
// depends on r2fft_pkg, r2fft_ram, r2fft_bfly
// load: one sample per cycle unless an apb write holds sample_ready low; compute: two reads,
// operand capture and multiply, two writes per butterfly, (n/2)*log2(n) butterflies;
// inverse adds a scaling read and write per point; emit: one point per cycle while result_ready.
// reset (arst_n low) clears control, log2_points to 6, inverse_mode to 0; stores undefined
module radix2_complex_fft_core import r2fft_pkg::*; #(
	parameter int MAX_POINTS  = MaxPointsDef,
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CfgAddrBits-1:0]        paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [ValBits-1:0]     result_re,
	output logic signed [ValBits-1:0]     result_im,
	output logic                          last_result
);
	localparam int AW = 6;  // store address bits, twiddle table limits length to 64
	localparam int MaxLogRaw = $clog2(MAX_POINTS);
	localparam int MaxLog = (MaxLogRaw > TwLog) ? TwLog : ((MaxLogRaw < 1) ? 1 : MaxLogRaw);

	// sequencer states
	typedef enum logic [7:0] {
		S_LOAD  = 8'b0000_0001,
		S_RDU   = 8'b0000_0010,
		S_RDV   = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_WRU   = 8'b0001_0000,
		S_WRV   = 8'b0010_0000,
		S_SCALE = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [2:0]       log2_q;
	logic             inv_q;
	logic [AW:0]      load_cnt_q;
	logic [2:0]       stage_q;   // current stage, 1..k
	logic [AW-1:0]    bfly_q;    // butterfly index within stage
	logic [AW:0]      emit_q;    // points sent (read address leads)
	logic             sc_ph_q;   // scale: read/write phase
	val_t             ur_q, ui_q;
	val_t             yr_q, yi_q;
	logic             out_v_q, out_last_q;
	val_t             out_re_q, out_im_q;

	logic [2:0]    k;
	logic [AW:0]   n;
	logic [AW-1:0] u_addr, v_addr, ld_addr, half, jpos;
	logic [4:0]    tw_idx;
	logic          cfg_wr;

	// effective length
	always_comb begin
		if (log2_q < 3'd1) k = 3'd1;
		else if (32'(log2_q) > MaxLog) k = 3'(MaxLog);
		else k = log2_q;
		n = (AW+1)'(1) << k;
	end

	// butterfly addressing: j = low (stage-1) bits of bfly, group from the rest
	always_comb begin
		logic [AW-1:0] mask;
		mask   = (AW'(1) << (stage_q - 3'd1)) - AW'(1);
		half   = AW'(1) << (stage_q - 3'd1);
		jpos   = bfly_q & mask;
		u_addr = ((bfly_q & ~mask) << 1) | jpos;
		v_addr = u_addr | half;
		tw_idx = 5'((jpos << (TwLog - 32'(stage_q))));
	end

	// bit-reversed load address
	always_comb begin
		ld_addr = '0;
		for (int i = 0; i < AW; i++)
			if (i < 32'(k)) ld_addr[32'(k)-1-i] = load_cnt_q[i];
	end

	// apb: always ready, writes on access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr)
			RegLog2Points:  prdata = {29'd0, log2_q};
			RegInverseMode: prdata = {31'd0, inv_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ram ports
	logic          we;
	logic [AW-1:0] waddr, raddr;
	val_t          wre, wim, rre, rim;

	r2fft_ram #(.Width(ValBits), .Depth(1 << AW)) u_re (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wre), .raddr(raddr), .rdata(rre));
	r2fft_ram #(.Width(ValBits), .Depth(1 << AW)) u_im (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wim), .raddr(raddr), .rdata(rim));

	// v operand goes straight from the ram output into the product registers
	val_t bxr, bxi, byr, byi;
	r2fft_bfly u_bfly (
		.clk(clk), .tw_idx(tw_idx), .inverse(inv_q),
		.ur(ur_q), .ui(ui_q), .vr(rre), .vi(rim),
		.xr(bxr), .xi(bxi), .yr(byr), .yi(byi));

	// inverse scaling: rounded arithmetic shift by k
	val_t sc_re, sc_im;
	always_comb begin
		logic signed [ValBits:0] r, a, b;
		r = (ValBits+1)'(1) << (k - 3'd1);
		a = (ValBits+1)'(rre) + r;
		b = (ValBits+1)'(rim) + r;
		sc_re = ValBits'(a >>> k);
		sc_im = ValBits'(b >>> k);
	end

	logic out_free, emit_go;
	assign out_free     = !out_v_q || result_ready;
	assign sample_ready = (state_q == S_LOAD) && !cfg_wr;
	assign emit_go      = (state_q == S_EMIT) && out_free && (emit_q <= n);

	// memory port muxing
	always_comb begin
		we = 1'b0; waddr = ld_addr; wre = ValBits'(sample_re); wim = ValBits'(sample_im);
		raddr = u_addr;
		unique case (state_q)
			S_LOAD: we = sample_valid && sample_ready;
			S_RDU:  raddr = u_addr;
			S_RDV:  raddr = v_addr;
			S_WRU: begin
				we = 1'b1; waddr = u_addr; wre = bxr; wim = bxi;
			end
			S_WRV: begin
				// read of point 0 primes the emit path
				we = 1'b1; waddr = v_addr; wre = yr_q; wim = yi_q; raddr = '0;
			end
			S_SCALE: begin
				raddr = sc_ph_q ? '0 : emit_q[AW-1:0];
				we = sc_ph_q; waddr = emit_q[AW-1:0]; wre = sc_re; wim = sc_im;
			end
			S_EMIT: raddr = emit_go ? emit_q[AW-1:0] + AW'(1) : emit_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WRU) begin
			yr_q <= byr;
			yi_q <= byi;
		end
		if (state_q == S_RDV) begin
			ur_q <= rre;
			ui_q <= rim;
		end
		if (emit_go) begin
			out_re_q <= rre;
			out_im_q <= rim;
			out_last_q <= (emit_q == n - (AW+1)'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			log2_q     <= 3'd6;
			inv_q      <= 1'b0;
			load_cnt_q <= '0;
			stage_q    <= 3'd1;
			bfly_q     <= '0;
			emit_q     <= '0;
			sc_ph_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (emit_go) out_v_q <= 1'b1;
			else if (result_ready) out_v_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr == RegLog2Points) begin
					log2_q <= pwdata[2:0]; load_cnt_q <= '0;
				end else if (paddr == RegInverseMode) begin
					inv_q <= pwdata[0]; load_cnt_q <= '0;
				end
			end
			unique case (state_q)
				S_LOAD: if (sample_valid && sample_ready) begin
					if (load_cnt_q + (AW+1)'(1) >= n) begin
						load_cnt_q <= '0;
						state_q <= S_RDU; stage_q <= 3'd1; bfly_q <= '0;
					end else load_cnt_q <= load_cnt_q + (AW+1)'(1);
				end
				S_RDU: state_q <= S_RDV;
				S_RDV: state_q <= S_MUL;
				S_MUL: state_q <= S_WRU;   // v data on ram output, products form
				S_WRU: state_q <= S_WRV;
				S_WRV: begin
					if ((AW+1)'(bfly_q) == (n >> 1) - (AW+1)'(1)) begin
						bfly_q <= '0;
						if (stage_q == k) begin
							emit_q <= '0; sc_ph_q <= 1'b0;
							state_q <= inv_q ? S_SCALE : S_EMIT;
						end else begin
							stage_q <= stage_q + 3'd1; state_q <= S_RDU;
						end
					end else begin
						bfly_q <= bfly_q + AW'(1); state_q <= S_RDU;
					end
				end
				S_SCALE: begin
					sc_ph_q <= !sc_ph_q;
					if (sc_ph_q) begin
						if (emit_q == n - (AW+1)'(1)) begin
							emit_q <= '0; state_q <= S_EMIT;
						end else emit_q <= emit_q + (AW+1)'(1);
					end
				end
				S_EMIT: begin
					// point 0 was read in the cycle before; emit_q counts sent points
					if (emit_go) begin
						if (emit_q == n - (AW+1)'(1)) begin
							emit_q <= '0; state_q <= S_LOAD;
						end else emit_q <= emit_q + (AW+1)'(1);
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign result_valid = out_v_q;
	assign result_re    = out_re_q;
	assign result_im    = out_im_q;
	assign last_result  = out_last_q;
endmodule
